// ----- src/slgc_pkg.sv -----
// Shared types, constants and table generators for the stereo limiter gain computer.
package slgc_pkg;

  localparam int PEAK_BITS_DEF      = 16;
  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int FIFO_DEPTH         = 4;

  // 20*log10(2) and its inverse, both Q16
  localparam int DB_PER_LOG2_Q16 = 394566;
  localparam int LOG2_PER_DB_Q16 = 10885;
  localparam int FLOOR_DB_Q8     = -24576;
  localparam logic [15:0] UNITY_GAIN = 16'h8000;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_FACTOR    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               enable;
    logic signed [15:0] threshold_db;
    logic [15:0]        compression_factor;
  } cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v     = v_in;
    res   = '0;
    bit_w = 64'h1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v   = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^ltb) in Q16, digit by digit through repeated squaring
  function automatic logic [17:0] log_entry(input int ltb, input int i);
    logic [63:0] y;
    logic [31:0] bits;
    y    = 64'((1 << ltb) + i) << (30 - ltb);
    bits = '0;
    if (i == (1 << ltb)) return 18'd65536;
    for (int b = 0; b < 16; b++) begin
      y    = (y * y) >> 30;
      bits = bits << 1;
      if (y >= (64'd2 << 30)) begin
        bits = bits | 32'd1;
        y    = y >> 1;
      end
    end
    return 18'(bits);
  endfunction

  // 2^(i/2^ltb) in Q16 from a product of truncated Q30 roots of two
  function automatic logic [17:0] exp_entry(input int ltb, input int i);
    logic [63:0] roots [11];
    logic [63:0] acc;
    roots[0] = 64'd2 << 30;
    acc      = 64'd1 << 30;
    for (int b = 1; b < 11; b++) begin
      roots[b] = (b <= ltb) ? isqrt64(roots[b-1] << 30) : 64'd0;
    end
    if (i == (1 << ltb)) return 18'd131072;
    for (int b = 0; b < 10; b++) begin
      if (b < ltb && ((i >> b) & 1) == 1) acc = (acc * roots[ltb-b]) >> 30;
    end
    return 18'(acc >> 14);
  endfunction

endpackage

// ----- src/slgc_ifs.sv -----
// Channel interfaces: peak input, gain output and configuration write.
interface slgc_peak_if;
  logic        valid;
  logic        ready;
  logic [15:0] peak_left;
  logic [15:0] peak_right;
  modport source(output valid, peak_left, peak_right, input ready);
  modport sink(input valid, peak_left, peak_right, output ready);
endinterface

interface slgc_gain_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain_left;
  logic [15:0] gain_right;
  modport source(output valid, gain_left, gain_right, input ready);
  modport sink(input valid, gain_left, gain_right, output ready);
endinterface

interface slgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/slgc_front.sv -----
// Front end: accept peak pairs, drop suppressed items, compute log2 of each level.
module slgc_front import slgc_pkg::*; #(
  parameter int PEAK_BITS      = PEAK_BITS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  localparam int L2W           = $clog2(PEAK_BITS) + 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slgc_peak_if.sink             peak_i,
  input  cfg_t                  cfg_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic signed [L2W-1:0] l2_left_o,
  output logic signed [L2W-1:0] l2_right_o
);

  localparam int SUB   = 16 - LOG_TABLE_BITS;
  localparam int TAB_N = 1 << LOG_TABLE_BITS;
  localparam logic [15:0] PEAK_MASK =
      (PEAK_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << PEAK_BITS) - 64'd1);

  logic [17:0] log_rom [TAB_N+1];
  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
    assign log_rom[gi] = log_entry(LOG_TABLE_BITS, gi);
  end

  logic        en;
  logic        keep;
  logic [15:0] pm [2];

  logic        s1_v_q, s2_v_q, s3_v_q;
  logic [15:0] s1_p_q [2];
  logic [4:0]  s2_m_q [2];
  logic [17:0] s2_t0_q [2];
  logic [16:0] s2_dt_q [2];
  logic [SUB-1:0] s2_rem_q [2];
  logic signed [L2W-1:0] s3_l2_q [2];

  logic [4:0]  m_d [2];
  logic [15:0] f_d [2];
  logic [17:0] t0_d [2];
  logic [16:0] dt_d [2];
  logic signed [L2W-1:0] l2_d [2];
  logic [LOG_TABLE_BITS:0] idx_w [2];
  logic [16+SUB:0] dmul [2];

  assign en           = !s3_v_q || !full_i;
  assign peak_i.ready = en;
  assign pm[0]        = peak_i.peak_left & PEAK_MASK;
  assign pm[1]        = peak_i.peak_right & PEAK_MASK;
  assign keep = cfg_i.enable && (cfg_i.compression_factor != '0) &&
                (pm[0] != '0) && (pm[1] != '0);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      m_d[c] = '0;
      for (int b = 0; b < 16; b++) begin
        if (s1_p_q[c][b]) m_d[c] = 5'(b);
      end
      // align the mantissa below the leading one to a 16-bit fraction
      f_d[c]   = 16'({s1_p_q[c], 16'h0} >> m_d[c]);
      idx_w[c] = {1'b0, f_d[c][15:SUB]};
      t0_d[c]  = log_rom[idx_w[c]];
      dt_d[c]  = 17'(log_rom[idx_w[c] + 1'b1] - t0_d[c]);
      dmul[c]  = s2_dt_q[c] * s2_rem_q[c];
      l2_d[c]  = ((L2W'(signed'({1'b0, s2_m_q[c]})) - L2W'(PEAK_BITS - 1)) <<< 16) +
                 signed'(L2W'(s2_t0_q[c])) + signed'(L2W'(dmul[c] >> SUB));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= peak_i.valid && keep;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end else if (push_o) begin
      s3_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        s1_p_q[c]   <= pm[c];
        s2_m_q[c]   <= m_d[c];
        s2_t0_q[c]  <= t0_d[c];
        s2_dt_q[c]  <= dt_d[c];
        s2_rem_q[c] <= f_d[c][SUB-1:0];
        s3_l2_q[c]  <= l2_d[c];
      end
    end
  end

  assign push_o     = s3_v_q && !full_i;
  assign l2_left_o  = s3_l2_q[0];
  assign l2_right_o = s3_l2_q[1];

endmodule

// ----- src/slgc_fifo.sv -----
// Short queue between front and back ends.
module slgc_fifo import slgc_pkg::*; #(
  parameter int W = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [W-1:0]  mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- src/slgc_back.sv -----
// Back end: level in dB, gain in dB, exp2 back to a linear gain, output register.
module slgc_back import slgc_pkg::*; #(
  parameter int PEAK_BITS      = PEAK_BITS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  localparam int L2W           = $clog2(PEAK_BITS) + 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  empty_i,
  input  logic signed [L2W-1:0] l2_left_i,
  input  logic signed [L2W-1:0] l2_right_i,
  output logic                  pop_o,
  slgc_gain_if.source           gain_o
);

  localparam int SUB   = 16 - LOG_TABLE_BITS;
  localparam int TAB_N = 1 << LOG_TABLE_BITS;
  localparam int PW1   = L2W + 20;
  localparam int LEVW  = PW1 - 24;
  localparam int DW    = LEVW + 1;
  localparam int PW2   = DW + 17;
  localparam int GW    = PW2 - 8;
  localparam logic signed [19:0] DB_K = 20'(DB_PER_LOG2_Q16);
  localparam logic signed [14:0] L2_K = 15'(LOG2_PER_DB_Q16);

  logic [17:0] exp_rom [TAB_N+1];
  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
    assign exp_rom[gi] = exp_entry(LOG_TABLE_BITS, gi);
  end

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic signed [L2W-1:0] head [2];
  logic signed [PW1-1:0] p1_q [2];
  logic signed [PW2-1:0] p2_q [2];
  logic                  le2_q [2], le3_q [2], le4_q [2];
  logic signed [30:0]    p3_q [2];
  logic                  un3_q [2], un4_q [2];
  logic [17:0]           t0_q [2];
  logic [16:0]           dt_q [2];
  logic [SUB-1:0]        rem_q [2];
  logic [4:0]            sh_q [2];
  logic [15:0]           gain_q [2];

  logic signed [LEVW-1:0] lev [2];
  logic signed [DW-1:0]   diff [2];
  logic                   le_d [2];
  logic signed [PW2-1:0]  p2_d [2];
  logic signed [GW-1:0]   g [2];
  logic                   un_d [2];
  logic signed [15:0]     g16 [2];
  logic signed [30:0]     p3_d [2];
  logic signed [6:0]      k [2];
  logic [15:0]            frac [2];
  logic [LOG_TABLE_BITS:0] idx_w [2];
  logic [17:0]            t0_d [2];
  logic [16:0]            dt_d [2];
  logic signed [6:0]      sh_w [2];
  logic [16+SUB:0]        dmul [2];
  logic [17:0]            v [2];
  logic [15:0]            gain_d [2];
  logic signed [PW1-1:0]  p1_d [2];

  assign en    = !out_v_q || gain_o.ready;
  assign pop_o = en && !empty_i;
  assign head[0] = l2_left_i;
  assign head[1] = l2_right_i;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      p1_d[c] = PW1'(head[c]) * PW1'(DB_K);
      // arithmetic shifts give the floor of negative values
      lev[c]  = LEVW'(p1_q[c] >>> 24);
      diff[c] = DW'(cfg_i.threshold_db) - DW'(lev[c]);
      le_d[c] = DW'(lev[c]) <= DW'(cfg_i.threshold_db);
      p2_d[c] = PW2'(diff[c]) * PW2'(signed'({1'b0, cfg_i.compression_factor}));
      g[c]    = GW'(p2_q[c] >>> 8);
      un_d[c] = g[c] < GW'(FLOOR_DB_Q8);
      g16[c]  = un_d[c] ? 16'sd0 : g[c][15:0];
      p3_d[c] = 31'(g16[c]) * 31'(L2_K);
      k[c]    = p3_q[c][30:24];
      frac[c] = p3_q[c][23:8];
      idx_w[c] = {1'b0, frac[c][15:SUB]};
      t0_d[c] = exp_rom[idx_w[c]];
      dt_d[c] = 17'(exp_rom[idx_w[c] + 1'b1] - t0_d[c]);
      sh_w[c] = 7'sd1 - k[c];
      dmul[c] = dt_q[c] * rem_q[c];
      v[c]    = t0_q[c] + 18'(dmul[c] >> SUB);
      if (le4_q[c]) gain_d[c] = UNITY_GAIN;
      else if (un4_q[c]) gain_d[c] = '0;
      else gain_d[c] = 16'(v[c] >> sh_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= !empty_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        p1_q[c]   <= p1_d[c];
        p2_q[c]   <= p2_d[c];
        le2_q[c]  <= le_d[c];
        p3_q[c]   <= p3_d[c];
        le3_q[c]  <= le2_q[c];
        un3_q[c]  <= un_d[c];
        t0_q[c]   <= t0_d[c];
        dt_q[c]   <= dt_d[c];
        rem_q[c]  <= frac[c][SUB-1:0];
        sh_q[c]   <= sh_w[c][4:0];
        le4_q[c]  <= le3_q[c];
        un4_q[c]  <= un3_q[c];
        gain_q[c] <= gain_d[c];
      end
    end
  end

  assign gain_o.valid      = out_v_q;
  assign gain_o.gain_left  = gain_q[0];
  assign gain_o.gain_right = gain_q[1];

endmodule

// ----- src/stereo_limiter_gain_computer.sv -----
// Top level of the stereo limiter static gain computer.
//
//  port     dir   payload                       note
//  peak_i   in    peak_left, peak_right         linear Q1.15 levels
//  gain_o   out   gain_left, gain_right         linear Q1.15, 32768 = unity
//  cfg_i    in    index, data                   register write, always ready
//
// One peak pair per cycle is taken while the front end is not stalled by a
// full queue. Each pair passes the front end, the queue and the back end,
// whose registers hold level in dB, gain in dB, scale to log2, exp2 table
// read and interpolation with the final shift. Suppressed items are dropped
// at the front and give no transfer. A stalled output holds the back end
// only; the front end keeps filling the four-entry queue until it is full.
// Reset clears all valid flags and loads the register defaults.
module stereo_limiter_gain_computer import slgc_pkg::*; #(
  parameter int PEAK_BITS      = PEAK_BITS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slgc_peak_if.sink   peak_i,
  slgc_gain_if.source gain_o,
  slgc_cfg_if.sink    cfg_i
);

  localparam int L2W = $clog2(PEAK_BITS) + 18;

  cfg_t cfg_q;
  logic push, pop, full, empty;
  logic signed [L2W-1:0] f_l2_l, f_l2_r, b_l2_l, b_l2_r;
  logic [2*L2W-1:0] q_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable             <= 1'b0;
      cfg_q.threshold_db       <= -16'sd256;
      cfg_q.compression_factor <= 16'd256;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENABLE:    cfg_q.enable             <= cfg_i.data[0];
        CFG_THRESHOLD: cfg_q.threshold_db       <= signed'(cfg_i.data);
        CFG_FACTOR:    cfg_q.compression_factor <= cfg_i.data;
        default: ;
      endcase
    end
  end

  slgc_front #(.PEAK_BITS(PEAK_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_front (
    .clk_i, .rst_ni, .peak_i, .cfg_i(cfg_q), .full_i(full), .push_o(push),
    .l2_left_o(f_l2_l), .l2_right_o(f_l2_r)
  );

  slgc_fifo #(.W(2*L2W)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i({f_l2_l, f_l2_r}), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(q_out)
  );

  assign b_l2_l = signed'(q_out[2*L2W-1:L2W]);
  assign b_l2_r = signed'(q_out[L2W-1:0]);

  slgc_back #(.PEAK_BITS(PEAK_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .l2_left_i(b_l2_l),
    .l2_right_i(b_l2_r), .pop_o(pop), .gain_o
  );

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_o.valid |-> (gain_o.gain_left <= UNITY_GAIN && gain_o.gain_right <= UNITY_GAIN))
    else $error("gain above unity");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !gain_o.valid)
    else $error("output valid right after reset");

  a_disabled_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gain_o.valid |-> peak_i.ready)
    else $error("input stalled while output idle");

endmodule
